// ===== hdl/smwr_pkg.sv =====
`default_nettype none
package smwr_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MASS_BITS   = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int CFG_W       = 13;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [MASS_BITS-1:0] mass_t;
    typedef logic [CFG_W-1:0]     cfg_t;

    // outcome of one window search, handed to the merge stage
    typedef struct packed {
        logic  valid;
        logic  hit;
        addr_t first;
        addr_t last;
        logic  last_window;
    } res_t;

    // one result request
    typedef struct packed {
        addr_t range_first;
        addr_t range_last;
        logic  found;
        logic  last_of_run;
    } rsp_t;

endpackage
`default_nettype wire

// ===== hdl/smwr_if.sv =====
`default_nettype none
interface smwr_req_if;
    logic                valid;
    logic                ready;
    logic                kind;
    smwr_pkg::addr_t     load_index;
    smwr_pkg::mass_t     load_mass;
    smwr_pkg::mass_t     window_low;
    smwr_pkg::mass_t     window_high;
    logic                last_window;

    modport source (output valid, kind, load_index, load_mass, window_low, window_high,
                    last_window, input ready);
    modport sink   (input valid, kind, load_index, load_mass, window_low, window_high,
                    last_window, output ready);
endinterface

interface smwr_rsp_if;
    logic                valid;
    logic                ready;
    smwr_pkg::addr_t     range_first;
    smwr_pkg::addr_t     range_last;
    logic                found;
    logic                last_of_run;

    modport source (output valid, range_first, range_last, found, last_of_run, input ready);
    modport sink   (input valid, range_first, range_last, found, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hdl/smwr_search.sv =====
`default_nettype none
module smwr_search
(
    input  logic            clk,
    input  logic            rst_n,
    smwr_req_if.sink        req,
    input  smwr_pkg::cfg_t  table_size,
    input  logic            merge_rdy,
    output smwr_pkg::res_t  res
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BS_ADDR = 3'd1;
    localparam logic [2:0] S_BS_CMP  = 3'd2;
    localparam logic [2:0] S_PROBE   = 3'd3;
    localparam logic [2:0] S_DOWN    = 3'd4;
    localparam logic [2:0] S_UP_LB   = 3'd5;
    localparam logic [2:0] S_UP_UB   = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0]            state_reg, state_next;
    smwr_pkg::idx_t        n_reg, n_next;
    smwr_pkg::mass_t       lb_reg, lb_next;
    smwr_pkg::mass_t       ub_reg, ub_next;
    logic [smwr_pkg::MASS_BITS:0] sum_reg, sum_next;
    smwr_pkg::addr_t       lo_reg, lo_next;
    smwr_pkg::addr_t       hi_reg, hi_next;
    smwr_pkg::addr_t       mid_reg, mid_next;
    smwr_pkg::idx_t        idx_reg, idx_next;
    smwr_pkg::idx_t        first_reg, first_next;
    smwr_pkg::addr_t       last_reg, last_next;
    logic                  hit_reg, hit_next;
    logic                  lastw_reg, lastw_next;

    smwr_pkg::mass_t       mass_mem [smwr_pkg::TABLE_DEPTH];
    smwr_pkg::mass_t       rdata_reg;
    smwr_pkg::addr_t       rd_addr;
    logic                  wr_en;

    logic [smwr_pkg::MASS_BITS:0] cmp_x;
    logic [smwr_pkg::MASS_BITS:0] cmp_y;
    logic                  cmp_gt;

    smwr_pkg::idx_t        n_eff;
    smwr_pkg::addr_t       span;
    logic [smwr_pkg::ADDR_W:0] lohi_sum;
    smwr_pkg::idx_t        idx_inc;
    smwr_pkg::idx_t        idx_dec;

    assign req.ready = (state_reg == S_IDLE);
    assign wr_en     = req.valid && req.ready && (req.kind == smwr_pkg::KIND_LOAD);

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mass_mem[req.load_index] <= req.load_mass;
        end
        rdata_reg <= mass_mem[rd_addr];
    end

    // shared compare unit, operands picked by the step in progress
    always_comb
    begin
        case (state_reg)
            S_BS_CMP:
            begin
                cmp_x = {rdata_reg, 1'b0};
                cmp_y = sum_reg;
            end
            S_UP_UB:
            begin
                cmp_x = {1'b0, rdata_reg};
                cmp_y = {1'b0, ub_reg};
            end
            default:
            begin
                cmp_x = {1'b0, lb_reg};
                cmp_y = {1'b0, rdata_reg};
            end
        endcase
        cmp_gt = (cmp_x > cmp_y);
    end

    assign n_eff    = (table_size > smwr_pkg::CFG_W'(smwr_pkg::TABLE_DEPTH))
                      ? smwr_pkg::IDX_W'(smwr_pkg::TABLE_DEPTH)
                      : smwr_pkg::IDX_W'(table_size);
    assign span     = hi_reg - lo_reg;
    assign lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign idx_inc  = idx_reg + smwr_pkg::IDX_W'(1);
    assign idx_dec  = idx_reg - smwr_pkg::IDX_W'(1);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        lb_next    = lb_reg;
        ub_next    = ub_reg;
        sum_next   = sum_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        last_next  = last_reg;
        hit_next   = hit_reg;
        lastw_next = lastw_reg;
        rd_addr    = idx_reg[smwr_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.kind == smwr_pkg::KIND_QUERY)
                begin
                    lb_next    = req.window_low;
                    ub_next    = req.window_high;
                    sum_next   = {1'b0, req.window_low} + {1'b0, req.window_high};
                    lastw_next = req.last_window;
                    n_next     = n_eff;
                    lo_next    = '0;
                    hi_next    = smwr_pkg::ADDR_W'(n_eff - smwr_pkg::IDX_W'(1));
                    if (n_eff == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_BS_ADDR;
                    end
                end
            end
            S_BS_ADDR:
            begin
                if (span > smwr_pkg::ADDR_W'(1))
                begin
                    mid_next   = lohi_sum[smwr_pkg::ADDR_W:1];
                    rd_addr    = lohi_sum[smwr_pkg::ADDR_W:1];
                    state_next = S_BS_CMP;
                end
                else
                begin
                    idx_next   = {1'b0, lo_reg};
                    rd_addr    = lo_reg;
                    state_next = S_PROBE;
                end
            end
            S_BS_CMP:
            begin
                // entry above the window midpoint pulls the upper end down
                if (cmp_gt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg;
                end
                state_next = S_BS_ADDR;
            end
            S_PROBE, S_DOWN:
            begin
                if (!cmp_gt)
                begin
                    // entry at or above lower bound: keep walking down
                    if (idx_reg == '0)
                    begin
                        first_next = '0;
                        rd_addr    = '0;
                        state_next = S_UP_UB;
                    end
                    else
                    begin
                        idx_next   = idx_dec;
                        rd_addr    = idx_dec[smwr_pkg::ADDR_W-1:0];
                        state_next = S_DOWN;
                    end
                end
                else if (state_reg == S_DOWN)
                begin
                    idx_next   = idx_inc;
                    first_next = idx_inc;
                    rd_addr    = idx_inc[smwr_pkg::ADDR_W-1:0];
                    state_next = S_UP_UB;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[smwr_pkg::ADDR_W-1:0];
                    if (idx_inc >= n_reg)
                    begin
                        first_next = idx_inc;
                        state_next = S_UP_UB;
                    end
                    else
                    begin
                        state_next = S_UP_LB;
                    end
                end
            end
            S_UP_LB:
            begin
                if (cmp_gt)
                begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[smwr_pkg::ADDR_W-1:0];
                    if (idx_inc >= n_reg)
                    begin
                        first_next = idx_inc;
                        state_next = S_UP_UB;
                    end
                end
                else
                begin
                    first_next = idx_reg;
                    state_next = S_UP_UB;
                end
            end
            S_UP_UB:
            begin
                if (idx_reg >= n_reg || cmp_gt)
                begin
                    hit_next   = (idx_reg != first_reg);
                    last_next  = idx_dec[smwr_pkg::ADDR_W-1:0];
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[smwr_pkg::ADDR_W-1:0];
                end
            end
            S_FINISH:
            begin
                if (merge_rdy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        lb_reg    <= lb_next;
        ub_reg    <= ub_next;
        sum_reg   <= sum_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        idx_reg   <= idx_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        hit_reg   <= hit_next;
        lastw_reg <= lastw_next;
    end

    assign res.valid       = (state_reg == S_FINISH);
    assign res.hit         = hit_reg;
    assign res.first       = first_reg[smwr_pkg::ADDR_W-1:0];
    assign res.last        = last_reg;
    assign res.last_window = lastw_reg;

endmodule
`default_nettype wire

// ===== hdl/smwr_merge.sv =====
`default_nettype none
module smwr_merge
(
    input  logic            clk,
    input  logic            rst_n,
    input  smwr_pkg::res_t  res,
    output logic            merge_rdy,
    smwr_rsp_if.source      rsp
);

    logic            pv_reg, pv_next;
    smwr_pkg::addr_t pf_reg, pf_next;
    smwr_pkg::addr_t pl_reg, pl_next;
    logic            any_reg, any_next;

    smwr_pkg::rsp_t  q0_reg, q1_reg;
    logic            q0_valid_reg, q1_valid_reg;

    logic            take;
    logic            pop;
    logic            em0_v, em1_v;
    smwr_pkg::rsp_t  em0, em1;

    assign merge_rdy = !q0_valid_reg;
    assign take      = res.valid && merge_rdy;
    assign pop       = rsp.ready && q0_valid_reg;

    // pending range update and up to two emitted requests
    always_comb
    begin
        pv_next  = pv_reg;
        pf_next  = pf_reg;
        pl_next  = pl_reg;
        any_next = any_reg;
        em0_v    = 1'b0;
        em0      = '{range_first: pf_reg, range_last: pl_reg, found: 1'b1, last_of_run: 1'b0};

        if (res.hit)
        begin
            if (!pv_reg)
            begin
                pv_next = 1'b1;
                pf_next = res.first;
                pl_next = res.last;
            end
            else if (pl_reg > res.first)
            begin
                pl_next = res.last;
            end
            else
            begin
                em0_v    = 1'b1;
                any_next = 1'b1;
                pf_next  = res.first;
                pl_next  = res.last;
            end
        end

        em1_v = res.last_window && (pv_next || !any_next);
        if (pv_next)
        begin
            em1 = '{range_first: pf_next, range_last: pl_next, found: 1'b1, last_of_run: 1'b1};
        end
        else
        begin
            em1 = '{range_first: '0, range_last: '0, found: 1'b0, last_of_run: 1'b1};
        end

        if (res.last_window)
        begin
            pv_next  = 1'b0;
            pf_next  = '0;
            pl_next  = '0;
            any_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg       <= 1'b0;
            pf_reg       <= '0;
            pl_reg       <= '0;
            any_reg      <= 1'b0;
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            pv_reg  <= pv_next;
            pf_reg  <= pf_next;
            pl_reg  <= pl_next;
            any_reg <= any_next;
            if (em0_v)
            begin
                q0_valid_reg <= 1'b1;
                q1_valid_reg <= em1_v;
            end
            else
            begin
                q0_valid_reg <= em1_v;
                q1_valid_reg <= 1'b0;
            end
        end
        else if (pop)
        begin
            q0_valid_reg <= q1_valid_reg;
            q1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q0_reg <= em0_v ? em0 : em1;
            q1_reg <= em1;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign rsp.valid       = q0_valid_reg;
    assign rsp.range_first = q0_reg.range_first;
    assign rsp.range_last  = q0_reg.range_last;
    assign rsp.found       = q0_reg.found;
    assign rsp.last_of_run = q0_reg.last_of_run;

endmodule
`default_nettype wire

// ===== hdl/sorted_mass_window_range_merge.sv =====
// sorted mass table with window range search and range merging
//
// req channel (valid/ready): kind 0 writes load_mass into the table at load_index,
// kind 1 is a mass window query (window_low, window_high, last_window).
// rsp channel (valid/ready): merged index ranges; found 0 marks a window set with
// no match, last_of_run flags the final request of a set.
// cfg_wr_en/cfg_wr_data: writes table_size, the count of valid sorted entries;
// write it only while the block is idle.
//
// a load is written into the table as it is taken. a query runs a binary search,
// each step an address state and a compare state, then the lower and upper
// boundary walks, which visit one entry per step. the single table read port
// sets this: every step is one registered memory read feeding one compare.
// one query is in flight at a time; req.ready is low while it runs,
// and loads are taken only while no query runs.
// results wait in a two-deep output register, so the next request is taken while
// they are still unread. when the receiver stalls, a finished query holds in its
// last step until both output slots are free.
// reset clears the pending range, the output slots and table_size; the table
// contents are undefined until loaded and need no clearing pass.
`default_nettype none
module sorted_mass_window_range_merge
(
    input  logic               clk,
    input  logic               rst_n,
    smwr_req_if.sink           req,
    smwr_rsp_if.source         rsp,
    input  logic               cfg_wr_en,
    input  smwr_pkg::cfg_t     cfg_wr_data
);

    smwr_pkg::cfg_t table_size_reg;
    smwr_pkg::res_t res;
    logic           merge_rdy;

    // table size register, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            table_size_reg <= cfg_wr_data;
        end
    end

    // binary search and boundary walks over the table memory
    smwr_search u_search
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .table_size (table_size_reg),
        .merge_rdy  (merge_rdy),
        .res        (res)
    );

    // pending range merge and output slots
    smwr_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .merge_rdy (merge_rdy),
        .rsp       (rsp)
    );

    // a search outcome is only offered while no new request can be taken
    a_res_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !req.ready)
        else $error("search outcome while input is open");

    // closing a window set always leaves a request in the output slot
    a_set_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && merge_rdy && res.last_window) |=> rsp.valid)
        else $error("window set closed without a result");

    // a found range is never inverted
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.hit) |-> (res.first <= res.last))
        else $error("found range has first above last");

endmodule
`default_nettype wire
